// ===== design/rrp_pkg.sv =====
// Package for the reply stream parser.
// Holds the shared widths, character and type codes, phase codes and the result word type.
// No dependencies.
package rrp_pkg;

  localparam int unsigned LEN_WIDTH = 32;
  localparam int unsigned POS_WIDTH = 34;

  localparam logic [63:0] LEN_LIMIT = (64'd1 << LEN_WIDTH) - 64'd1;
  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [3:0] TY_SIMPLE = 4'd0;
  localparam logic [3:0] TY_SIMERR = 4'd1;
  localparam logic [3:0] TY_INT    = 4'd2;
  localparam logic [3:0] TY_BULK   = 4'd3;
  localparam logic [3:0] TY_BULKER = 4'd4;
  localparam logic [3:0] TY_VERB   = 4'd5;
  localparam logic [3:0] TY_ARRAY  = 4'd6;
  localparam logic [3:0] TY_SET    = 4'd7;
  localparam logic [3:0] TY_PUSH   = 4'd8;
  localparam logic [3:0] TY_MAP    = 4'd9;
  localparam logic [3:0] TY_NULL   = 4'd10;
  localparam logic [3:0] TY_BOOL   = 4'd11;
  localparam logic [3:0] TY_DOUBLE = 4'd12;
  localparam logic [3:0] TY_BIGNUM = 4'd13;

  localparam logic [2:0] PH_TYPE = 3'd0;
  localparam logic [2:0] PH_LINE = 3'd1;
  localparam logic [2:0] PH_BODY = 3'd2;
  localparam logic [2:0] PH_BCR  = 3'd3;
  localparam logic [2:0] PH_BLF  = 3'd4;

  typedef struct packed {
    logic                 ok;
    logic [3:0]           value_type;
    logic [63:0]          int_value;
    logic [LEN_WIDTH-1:0] str_offset;
    logic [LEN_WIDTH-1:0] str_len;
    logic [LEN_WIDTH-1:0] child_count;
    logic [POS_WIDTH-1:0] octets_used;
  } rrp_res_t;

endpackage

// ===== design/rrp_in_stage.sv =====
// Input register of the reply stream parser.
// Holds one accepted word until the parser core consumes it; uses rrp_pkg.
module rrp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       restart_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       restart_o
);
  import rrp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       restart_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= data_byte_i;
      restart_q <= restart_i;
    end
  end

  assign valid_o   = valid_q;
  assign byte_o    = byte_q;
  assign restart_o = restart_q;
endmodule

// ===== design/rrp_core.sv =====
// Parser core: state registers and the one-step next-state and result logic.
// Consumes one word per advance; uses rrp_pkg.
module rrp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [7:0]        byte_i,
  input  logic              restart_i,
  output logic              res_valid_o,
  output rrp_pkg::rrp_res_t res_o
);
  import rrp_pkg::*;

  typedef struct packed {
    logic [63:0]          acc;
    logic                 minus;
    logic                 dnz;
    logic                 malformed;
    logic [LEN_WIDTH-1:0] len;
    logic                 over;
    logic [7:0]           first;
  } line_t;

  function automatic line_t line_char(line_t s, logic [7:0] c);
    line_t      r;
    logic [7:0] dig;
    r   = s;
    dig = c - CH_ZERO;
    if (s.len == '0) begin
      r.first = c;
    end
    if (s.len == '0 && c == CH_MINUS) begin
      r.minus = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      r.acc = (s.acc << 3) + (s.acc << 1) + {60'd0, dig[3:0]};
      r.dnz = 1'b1;
    end else begin
      r.malformed = 1'b1;
    end
    if (&s.len) begin
      r.over = 1'b1;
    end else begin
      r.len = s.len + 1'b1;
    end
    return r;
  endfunction

  logic [2:0]           phase_q, phase_d;
  logic [3:0]           type_q, type_d;
  line_t                line_q, line_d, lt;
  logic                 pcr_q, pcr_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d, pos_inc;
  logic [LEN_WIDTH-1:0] brem_q, brem_d, brem_dec;
  logic [LEN_WIDTH-1:0] blen_q, blen_d;
  logic [3:0]           tcode;
  logic                 tknown;
  logic [63:0]          v;
  logic                 num_ok;
  logic                 neg;
  logic                 em, fl;
  rrp_res_t             res;

  always_comb begin
    tknown = 1'b1;
    unique case (byte_i)
      CH_PLUS:   tcode = TY_SIMPLE;
      CH_MINUS:  tcode = TY_SIMERR;
      CH_COLON:  tcode = TY_INT;
      CH_DOLLAR: tcode = TY_BULK;
      CH_BANG:   tcode = TY_BULKER;
      CH_EQUAL:  tcode = TY_VERB;
      CH_STAR:   tcode = TY_ARRAY;
      CH_TILDE:  tcode = TY_SET;
      CH_GT:     tcode = TY_PUSH;
      CH_PCT:    tcode = TY_MAP;
      CH_UNDER:  tcode = TY_NULL;
      CH_HASH:   tcode = TY_BOOL;
      CH_COMMA:  tcode = TY_DOUBLE;
      CH_LPAREN: tcode = TY_BIGNUM;
      default: begin
        tcode  = TY_SIMPLE;
        tknown = 1'b0;
      end
    endcase
  end

  assign v        = line_q.minus ? (64'd0 - line_q.acc) : line_q.acc;
  assign num_ok   = line_q.dnz && !line_q.malformed;
  assign neg      = v[63];
  assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
  assign brem_dec = (brem_q != '0) ? brem_q - 1'b1 : brem_q;

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    line_d  = line_q;
    pcr_d   = pcr_q;
    pos_d   = pos_q;
    brem_d  = brem_q;
    blen_d  = blen_q;
    lt      = line_q;
    res     = '0;
    em      = 1'b0;
    fl      = 1'b0;
    if (restart_i || phase_q == PH_TYPE || phase_q > PH_BLF) begin
      line_d = '0;
      pcr_d  = 1'b0;
      brem_d = '0;
      blen_d = '0;
      pos_d  = POS_WIDTH'(1);
      if (tknown) begin
        type_d  = tcode;
        phase_d = PH_LINE;
      end else begin
        type_d         = TY_SIMPLE;
        res.ok         = 1'b0;
        res.value_type = TY_SIMPLE;
        em             = 1'b1;
      end
    end else begin
      pos_d = pos_inc;
      unique case (phase_q)
        PH_LINE: begin
          if (pcr_q && byte_i == CH_LF) begin
            pcr_d = 1'b0;
            if (line_q.over) begin
              fl = 1'b1;
            end else begin
              unique case (type_q)
                TY_SIMPLE, TY_SIMERR, TY_DOUBLE, TY_BIGNUM: begin
                  em             = 1'b1;
                  res.ok         = 1'b1;
                  res.value_type = type_q;
                  res.str_offset = LEN_WIDTH'(1);
                  res.str_len    = line_q.len;
                end
                TY_INT: begin
                  if (!num_ok) begin
                    fl = 1'b1;
                  end else begin
                    em             = 1'b1;
                    res.ok         = 1'b1;
                    res.value_type = TY_INT;
                    res.int_value  = v;
                  end
                end
                TY_BULK, TY_BULKER, TY_VERB: begin
                  if (!num_ok) begin
                    fl = 1'b1;
                  end else if (type_q == TY_BULK && &v) begin
                    em             = 1'b1;
                    res.ok         = 1'b1;
                    res.value_type = TY_NULL;
                  end else if (neg || v > LEN_LIMIT) begin
                    fl = 1'b1;
                  end else begin
                    blen_d  = v[LEN_WIDTH-1:0];
                    brem_d  = v[LEN_WIDTH-1:0];
                    phase_d = (v != 64'd0) ? PH_BODY : PH_BCR;
                  end
                end
                TY_ARRAY, TY_SET, TY_PUSH: begin
                  if (!num_ok) begin
                    fl = 1'b1;
                  end else if (type_q == TY_ARRAY && &v) begin
                    em             = 1'b1;
                    res.ok         = 1'b1;
                    res.value_type = TY_NULL;
                  end else if (neg || v > LEN_LIMIT) begin
                    fl = 1'b1;
                  end else begin
                    em              = 1'b1;
                    res.ok          = 1'b1;
                    res.value_type  = type_q;
                    res.int_value   = v;
                    res.child_count = v[LEN_WIDTH-1:0];
                  end
                end
                TY_MAP: begin
                  if (!num_ok || neg || v > (LEN_LIMIT >> 1)) begin
                    fl = 1'b1;
                  end else begin
                    em              = 1'b1;
                    res.ok          = 1'b1;
                    res.value_type  = TY_MAP;
                    res.int_value   = v << 1;
                    res.child_count = {v[LEN_WIDTH-2:0], 1'b0};
                  end
                end
                TY_NULL: begin
                  em             = 1'b1;
                  res.ok         = 1'b1;
                  res.value_type = TY_NULL;
                end
                TY_BOOL: begin
                  if (line_q.len != LEN_WIDTH'(1) ||
                      (line_q.first != CH_T && line_q.first != CH_F)) begin
                    fl = 1'b1;
                  end else begin
                    em             = 1'b1;
                    res.ok         = 1'b1;
                    res.value_type = TY_BOOL;
                    res.int_value  = {63'd0, line_q.first == CH_T};
                  end
                end
                default: fl = 1'b1;
              endcase
            end
          end else begin
            if (pcr_q) begin
              lt = line_char(lt, CH_CR);
            end
            if (byte_i == CH_CR) begin
              pcr_d = 1'b1;
            end else begin
              pcr_d = 1'b0;
              lt    = line_char(lt, byte_i);
            end
            line_d = lt;
          end
        end
        PH_BODY: begin
          brem_d = brem_dec;
          if (brem_dec == '0) begin
            phase_d = PH_BCR;
          end
        end
        PH_BCR: begin
          if (byte_i != CH_CR) begin
            fl = 1'b1;
          end else begin
            phase_d = PH_BLF;
          end
        end
        PH_BLF: begin
          if (byte_i != CH_LF) begin
            fl = 1'b1;
          end else begin
            em             = 1'b1;
            res.ok         = 1'b1;
            res.value_type = type_q;
            res.str_offset = line_q.len + LEN_WIDTH'(3);
            res.str_len    = blen_q;
          end
        end
        default: ;
      endcase
    end
    if (fl) begin
      res            = '0;
      res.value_type = type_q;
    end
    if (em || fl) begin
      phase_d         = PH_TYPE;
      res.octets_used = pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= TY_SIMPLE;
      line_q  <= '0;
      pcr_q   <= 1'b0;
      pos_q   <= '0;
      brem_q  <= '0;
      blen_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      line_q  <= line_d;
      pcr_q   <= pcr_d;
      pos_q   <= pos_d;
      brem_q  <= brem_d;
      blen_q  <= blen_d;
    end
  end

  assign res_valid_o = em || fl;
  assign res_o       = res;
endmodule

// ===== design/rrp_out_stage.sv =====
// Result register of the reply stream parser.
// Holds one result word until the consumer takes it; uses rrp_pkg.
module rrp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rrp_pkg::rrp_res_t res_i,
  output logic              can_take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrp_pkg::rrp_res_t res_o
);
  import rrp_pkg::*;

  logic     valid_q, valid_d;
  rrp_res_t res_q;

  assign can_take_o = !valid_q || out_ready_i;
  assign valid_d    = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
endmodule

// ===== design/resp_reply_parser_top.sv =====
// Top level of the reply stream parser.
// Instantiates rrp_in_stage, rrp_core and rrp_out_stage; uses rrp_pkg.
//
// The parser takes one octet of a reply stream per cycle while in_ready_o is high and
// gives one result word for each complete value, at the CRLF that ends its header line or
// its bulk body, or at an unknown type octet or a wrong octet after a bulk body. Each octet
// passes an input register and one step of the parser core; the result word of the octet
// that ends a value is loaded into the result register as the core consumes that octet, and
// a new octet is accepted every cycle while the result register is empty or being drained.
// The sustained rate is one octet per cycle while the result register can take a word.
module resp_reply_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic [3:0]         value_type_o,
  output logic signed [63:0] int_value_o,
  output logic [31:0]        str_offset_o,
  output logic [31:0]        str_len_o,
  output logic [31:0]        child_count_o,
  output logic [33:0]        octets_used_o
);
  import rrp_pkg::*;

  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_restart;
  logic       advance;
  logic       can_take;
  logic       res_valid;
  rrp_res_t   res;
  rrp_res_t   res_q;

  assign advance = stg_valid && can_take;

  rrp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .take_i      (advance),
    .valid_o     (stg_valid),
    .byte_o      (stg_byte),
    .restart_o   (stg_restart)
  );

  rrp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (stg_byte),
    .restart_i   (stg_restart),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rrp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign ok_o          = res_q.ok;
  assign value_type_o  = res_q.value_type;
  assign int_value_o   = $signed(res_q.int_value);
  assign str_offset_o  = res_q.str_offset;
  assign str_len_o     = res_q.str_len;
  assign child_count_o = res_q.child_count;
  assign octets_used_o = res_q.octets_used;
endmodule

// ===== dv/resp_reply_parser_checker.sv =====
// Checker for the reply stream parser: watches both channels, predicts the result word of
// every complete value from the octets accepted, and compares each result word field by
// field. Depends on rrp_pkg.
module resp_reply_parser_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               ok_i,
  input  logic [3:0]         value_type_i,
  input  logic signed [63:0] int_value_i,
  input  logic [31:0]        str_offset_i,
  input  logic [31:0]        str_len_i,
  input  logic [31:0]        child_count_i,
  input  logic [33:0]        octets_used_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 rejected_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrp_pkg::*;

  logic [2:0]           ph;
  logic [3:0]           vtype;
  logic [63:0]          acc;
  logic                 neg_sign;
  logic                 saw_digit;
  logic                 bad_line;
  logic                 cr_held;
  logic                 line_ovf;
  logic [63:0]          line_len;
  logic [63:0]          body_left;
  logic [63:0]          body_total;
  logic [POS_WIDTH-1:0] pos;
  logic [7:0]           first_ch;

  rrp_res_t awaited_values[$];
  int       n_fail = 0;
  int       n_checked = 0;
  int       n_rejected = 0;

  function automatic void clear_parser();
    ph         = PH_TYPE;
    vtype      = TY_SIMPLE;
    acc        = '0;
    neg_sign   = 1'b0;
    saw_digit  = 1'b0;
    bad_line   = 1'b0;
    cr_held    = 1'b0;
    line_ovf   = 1'b0;
    line_len   = '0;
    body_left  = '0;
    body_total = '0;
    pos        = '0;
    first_ch   = '0;
  endfunction

  function automatic rrp_res_t make_result(logic ok, logic [3:0] t, logic [63:0] iv,
                                           logic [63:0] off, logic [63:0] slen,
                                           logic [63:0] cnt);
    rrp_res_t r;
    r.ok          = ok;
    r.value_type  = t;
    r.int_value   = iv;
    r.str_offset  = off[31:0];
    r.str_len     = slen[31:0];
    r.child_count = cnt[31:0];
    r.octets_used = pos;
    ph = PH_TYPE;
    return r;
  endfunction

  function automatic rrp_res_t reject();
    return make_result(1'b0, vtype, '0, '0, '0, '0);
  endfunction

  function automatic logic type_of(logic [7:0] b, output logic [3:0] t);
    t = TY_SIMPLE;
    case (b)
      CH_PLUS:   t = TY_SIMPLE;
      CH_MINUS:  t = TY_SIMERR;
      CH_COLON:  t = TY_INT;
      CH_DOLLAR: t = TY_BULK;
      CH_BANG:   t = TY_BULKER;
      CH_EQUAL:  t = TY_VERB;
      CH_STAR:   t = TY_ARRAY;
      CH_TILDE:  t = TY_SET;
      CH_GT:     t = TY_PUSH;
      CH_PCT:    t = TY_MAP;
      CH_UNDER:  t = TY_NULL;
      CH_HASH:   t = TY_BOOL;
      CH_COMMA:  t = TY_DOUBLE;
      CH_LPAREN: t = TY_BIGNUM;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void take_char(logic [7:0] c);
    if (line_len == 0) first_ch = c;
    if (line_len == 0 && c == CH_MINUS) begin
      neg_sign = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      acc       = acc * 64'd10 + 64'(c - CH_ZERO);
      saw_digit = 1'b1;
    end else begin
      bad_line = 1'b1;
    end
    if (line_len >= LEN_LIMIT) line_ovf = 1'b1;
    else line_len = line_len + 64'd1;
  endfunction

  function automatic logic open_value(logic [7:0] b, output rrp_res_t r);
    logic [3:0] code;
    logic       known;
    known = type_of(b, code);
    clear_parser();
    pos = 1;
    r   = '0;
    if (!known) begin
      r = make_result(1'b0, TY_SIMPLE, '0, '0, '0, '0);
      return 1'b1;
    end
    vtype = code;
    ph    = PH_LINE;
    return 1'b0;
  endfunction

  function automatic logic close_line(output rrp_res_t r);
    logic [63:0] v;
    logic        good;
    v    = neg_sign ? 64'd0 - acc : acc;
    good = saw_digit && !bad_line;
    r    = '0;
    if (line_ovf) begin
      r = reject();
      return 1'b1;
    end
    case (vtype)
      TY_SIMPLE, TY_SIMERR, TY_DOUBLE, TY_BIGNUM: begin
        r = make_result(1'b1, vtype, '0, 64'd1, line_len, '0);
      end
      TY_INT: begin
        r = good ? make_result(1'b1, TY_INT, v, '0, '0, '0) : reject();
      end
      TY_BULK, TY_BULKER, TY_VERB: begin
        if (!good) begin
          r = reject();
        end else if (vtype == TY_BULK && v == '1) begin
          r = make_result(1'b1, TY_NULL, '0, '0, '0, '0);
        end else if (v[63] || v > LEN_LIMIT) begin
          r = reject();
        end else begin
          body_total = v;
          body_left  = v;
          ph = (v != 0) ? PH_BODY : PH_BCR;
          return 1'b0;
        end
      end
      TY_ARRAY, TY_SET, TY_PUSH: begin
        if (!good) begin
          r = reject();
        end else if (vtype == TY_ARRAY && v == '1) begin
          r = make_result(1'b1, TY_NULL, '0, '0, '0, '0);
        end else if (v[63] || v > LEN_LIMIT) begin
          r = reject();
        end else begin
          r = make_result(1'b1, vtype, v, '0, '0, v);
        end
      end
      TY_MAP: begin
        if (!good || v[63] || v > LEN_LIMIT / 2) r = reject();
        else r = make_result(1'b1, TY_MAP, v * 2, '0, '0, v * 2);
      end
      TY_NULL: begin
        r = make_result(1'b1, TY_NULL, '0, '0, '0, '0);
      end
      TY_BOOL: begin
        if (line_len != 1 || (first_ch != CH_T && first_ch != CH_F)) r = reject();
        else r = make_result(1'b1, TY_BOOL, {63'd0, first_ch == CH_T}, '0, '0, '0);
      end
      default: begin
        r = reject();
      end
    endcase
    return 1'b1;
  endfunction

  function automatic logic parse_octet(logic [7:0] b, logic rs, output rrp_res_t r);
    r = '0;
    if (rs || ph == PH_TYPE || ph > PH_BLF) return open_value(b, r);
    if (pos != POS_MAX) pos = pos + 1;
    case (ph)
      PH_LINE: begin
        if (cr_held && b == CH_LF) begin
          cr_held = 1'b0;
          return close_line(r);
        end
        if (cr_held) take_char(CH_CR);
        if (b == CH_CR) begin
          cr_held = 1'b1;
        end else begin
          cr_held = 1'b0;
          take_char(b);
        end
        return 1'b0;
      end
      PH_BODY: begin
        if (body_left != 0) body_left = body_left - 64'd1;
        if (body_left == 0) ph = PH_BCR;
        return 1'b0;
      end
      PH_BCR: begin
        if (b != CH_CR) begin
          r = reject();
          return 1'b1;
        end
        ph = PH_BLF;
        return 1'b0;
      end
      default: begin
        if (b != CH_LF) r = reject();
        else r = make_result(1'b1, vtype, '0, line_len + 64'd3, body_total, '0);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rrp_res_t want;
    rrp_res_t fresh;
    int       bad;
    if (!rst_ni) begin
      clear_parser();
      awaited_values.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_values.size() == 0) begin
          $error("Result word arrived with no value outstanding");
          n_fail++;
        end else begin
          want = awaited_values.pop_front();
          bad  = field_diff("ok", want.ok, ok_i);
          bad += field_diff("value_type", want.value_type, value_type_i);
          bad += field_diff("int_value", want.int_value, int_value_i);
          bad += field_diff("str_offset", want.str_offset, str_offset_i);
          bad += field_diff("str_len", want.str_len, str_len_i);
          bad += field_diff("child_count", want.child_count, child_count_i);
          bad += field_diff("octets_used", want.octets_used, octets_used_i);
          n_fail += bad;
          n_checked++;
          if (!want.ok) n_rejected++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_octet(data_byte_i, restart_i, fresh)) awaited_values.push_back(fresh);
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= awaited_values.size();
    checked_o    <= n_checked;
    rejected_o   <= n_rejected;
  end

endmodule

// ===== dv/resp_reply_parser_top_test.sv =====
// Testbench top for resp_reply_parser_top: drives reply octets and result back-pressure
// through several idling phases and gives the verdict.
// Depends on rrp_pkg, resp_reply_parser_checker and the parser RTL.
module resp_reply_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octet_q_t[$];

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [7:0]         data_byte = 8'h00;
  logic               restart = 1'b0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               ok;
  logic [3:0]         value_type;
  logic signed [63:0] int_value;
  logic [31:0]        str_offset;
  logic [31:0]        str_len;
  logic [31:0]        child_count;
  logic [33:0]        octets_used;

  int fail_count;
  int pending;
  int checked;
  int rejected;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int octets_sent = 0;

  always #1 clk = ~clk;

  resp_reply_parser_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .restart_i     (restart),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .ok_o          (ok),
    .value_type_o  (value_type),
    .int_value_o   (int_value),
    .str_offset_o  (str_offset),
    .str_len_o     (str_len),
    .child_count_o (child_count),
    .octets_used_o (octets_used)
  );

  resp_reply_parser_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .data_byte_i   (data_byte),
    .restart_i     (restart),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .ok_i          (ok),
    .value_type_i  (value_type),
    .int_value_i   (int_value),
    .str_offset_i  (str_offset),
    .str_len_i     (str_len),
    .child_count_i (child_count),
    .octets_used_i (octets_used),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .rejected_o    (rejected)
  );

  // A long hold-off, when requested, takes precedence over the random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_octet(input logic [7:0] b, input logic rs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    restart   <= rs;
    do @(posedge clk); while (!in_ready);
    octets_sent++;
    @(negedge clk);
  endtask

  task automatic send_octets(input octet_q_t q, input logic rs_first);
    foreach (q[i]) send_octet(q[i], rs_first && i == 0);
  endtask

  function automatic void add_text(ref octet_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_line_text(ref octet_q_t q, input int n);
    for (int i = 0; i < n; i++) begin
      q.push_back($urandom_range(0, 15) == 0 ? 8'($urandom) : 8'($urandom_range(32, 126)));
    end
  endfunction

  task automatic send_text(input string s, input logic rs_first);
    octet_q_t q;
    add_text(q, s);
    send_octets(q, rs_first);
  endtask

  task automatic set_idling(input int idle, input int stall, input int hold);
    in_valid <= 1'b0;
    @(posedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    hold_left     = hold;
    @(negedge clk);
  endtask

  function automatic string number_text();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return $sformatf("%0d", $urandom_range(0, 5));
    if (sel == 12) return "-1";
    if (sel == 13) return $sformatf("-%0d", $urandom_range(2, 99));
    if (sel == 14) return $sformatf("%0d", $urandom);
    if (sel == 15) return $sformatf("%0d", {$urandom, $urandom});
    if (sel == 16) return "4294967296";
    if (sel == 17) return "";
    if (sel == 18) return $sformatf("%0dx", $urandom_range(0, 9));
    return "+3";
  endfunction

  function automatic octet_q_t random_value();
    octet_q_t    q;
    string       type_chars;
    int unsigned pick;
    int unsigned n;
    int unsigned sel;
    type_chars = "+-:$!=*~>%_#,(";
    pick = $urandom_range(0, 13);
    sel  = $urandom_range(0, 9);
    q.push_back(type_chars[pick]);
    case (pick)
      2: begin
        if (sel < 6) add_text(q, $sformatf("%0d", $signed({$urandom, $urandom})));
        else if (sel < 8) add_text(q, $sformatf("%0d", $signed($urandom_range(0, 200)) - 100));
        else if (sel == 8) add_text(q, $sformatf("%0d%0d", {$urandom, $urandom}, $urandom));
        else add_text(q, number_text());
      end
      3, 4, 5: begin
        if (sel < 7) begin
          n = $urandom_range(0, 12);
          add_text(q, $sformatf("%0d\r\n", n));
          for (int i = 0; i < n; i++) q.push_back(8'($urandom));
        end else begin
          add_text(q, number_text());
        end
      end
      6, 7, 8: add_text(q, number_text());
      9: begin
        if (sel == 0) add_text(q, "2147483647");
        else if (sel == 1) add_text(q, "2147483648");
        else add_text(q, number_text());
      end
      11: begin
        if (sel < 4) add_text(q, "t");
        else if (sel < 8) add_text(q, "f");
        else add_line_text(q, $urandom_range(0, 3));
      end
      12: add_text(q, $sformatf("%0d.%0d", $signed($urandom), $urandom_range(0, 999)));
      13: add_text(q, $sformatf("%0d%0d", {$urandom, $urandom}, $urandom));
      default: add_line_text(q, $urandom_range(0, 10));
    endcase
    add_text(q, "\r\n");
    return q;
  endfunction

  // Mostly complete values; the rest are cut short, have a damaged ending, or are noise.
  task automatic random_phase(input int quota);
    octet_q_t    q;
    int unsigned roll;
    int unsigned keep;
    int          stop_at;
    logic        cut;
    cut     = 1'b0;
    stop_at = octets_sent + quota;
    while (octets_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_octet(8'($urandom), 1'($urandom));
      end else begin
        q = random_value();
        if (roll < 10) begin
          keep = $urandom_range(1, q.size() - 1);
          while (q.size() > keep) void'(q.pop_back());
        end else if (roll < 14) begin
          q[q.size() - 1 - $urandom_range(0, 1)] = 8'($urandom);
        end
        send_octets(q, cut || $urandom_range(0, 9) == 0);
        cut = (roll < 10);
      end
    end
  endtask

  initial begin
    string cases[$];
    int    guard;
    cases = '{"+OK\r\n", "-ERR a\rb\r\n", ":0\r\n", ":-9223372036854775808\r\n",
              ":9223372036854775807\r\n", ":99999999999999999999999\r\n", ":1-2\r\n",
              ":-\r\n", "$5\r\nhe\r\no\r\n", "$0\r\n\r\n", "$-1\r\n", "$-7\r\n",
              "$4294967296\r\n", "$2\r\nabXY", "$3\r\nabc\rZ", "!3\r\nerr\r\n",
              "=6\r\ntxt:ab\r\n", "*3\r\n", "*-1\r\n", "~4294967295\r\n", ">x\r\n",
              "%2147483647\r\n", "%2147483648\r\n", "%-1\r\n", "_\r\n", "_x\r\n",
              "#t\r\n", "#f\r\n", "#tt\r\n", ",-1.5\r\n", "(123456789012345678901\r\n",
              "?\r\n"};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (cases[i]) send_text(cases[i], 1'b0);
    send_octet(8'hFF, 1'b0);
    send_text("$4294967295\r\nxyz", 1'b0);
    send_text("+ok\r\n", 1'b1);
    send_text("+abc", 1'b0);
    send_text("#f\r\n", 1'b1);

    set_idling(0, 0, 300);
    random_phase(100);
    set_idling(59, 0, 0);
    random_phase(100);
    set_idling(0, 59, 0);
    random_phase(100);
    set_idling(10, 10, 0);
    random_phase(100);
    set_idling(0, 0, 0);

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (pending != 0) $error("%0d expected result words never arrived", pending);

    $display("Run covered %0d octets in four idling phases and one long result hold-off.",
             octets_sent);
    $display("Result words checked: %0d, of which %0d reported malformed values.",
             checked, rejected);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
